@@ sv/pssu_pkg.sv @@
// Shared types and constants for the parity-split sorted insert block.
package pssu_pkg;

    localparam int unsigned DEFAULT_LIST_DEPTH = 16;
    localparam int unsigned DEFAULT_VALUE_BITS = 8;

    localparam int unsigned CNT_W    = 5;
    localparam int unsigned STATUS_W = 2;

    localparam logic [CNT_W-1:0] LIMIT_RESET = 5'd10;

    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_INSERTED  = 2'd0,
        STATUS_DUPLICATE = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WALK,
        ST_TAIL,
        ST_REPORT
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    load_item;
        logic    read_first;
        logic    walk;
        logic    tail;
        logic    load_result;
        status_t status;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic full;
        logic empty;
        logic dup;
        logic last;
    } stat_t;

endpackage

@@ sv/pssu_if.sv @@
// Channel interfaces: input item, result item and configuration write.
interface pssu_item_if import pssu_pkg::*;
    #(parameter int unsigned VALUE_BITS = DEFAULT_VALUE_BITS);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface pssu_result_if import pssu_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                list_used;
    logic [CNT_W-1:0]    list_count;
    logic                both_full;

    modport source (output valid, output status, output list_used, output list_count,
                    output both_full, input ready);
    modport sink (input valid, input status, input list_used, input list_count,
                  input both_full, output ready);
endinterface

interface pssu_cfg_if import pssu_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] list_limit;

    modport source (output valid, output list_limit, input ready);
    modport sink (input valid, input list_limit, output ready);
endinterface

@@ sv/pssu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pssu_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/pssu_ctrl.sv @@
// Controller: sequences full check, list walk, tail write and result hand-off.
module pssu_ctrl import pssu_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_ready,
    output logic  result_valid,
    input  logic  result_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t  state_reg, state_next;
    status_t st_reg, st_next;
    logic    out_valid_reg, out_valid_next;
    logic    slot_free;

    assign slot_free = !out_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            st_reg        <= STATUS_INSERTED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (stat.full)
                begin
                    st_next    = STATUS_FULL;
                    state_next = ST_REPORT;
                end
                else if (stat.empty)
                begin
                    state_next = ST_TAIL;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (stat.dup)
                begin
                    st_next    = STATUS_DUPLICATE;
                    state_next = ST_REPORT;
                end
                else if (stat.last)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                st_next    = STATUS_INSERTED;
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd            = '0;
        cmd.status     = st_reg;
        item_ready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready    = 1'b1;
                cmd.load_item = item_valid;
            end
            ST_START:
            begin
                cmd.read_first = !stat.full && !stat.empty;
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
            end
            ST_TAIL:
            begin
                cmd.tail = 1'b1;
            end
            ST_REPORT:
            begin
                cmd.load_result = slot_free;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase

        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

@@ sv/pssu_dp.sv @@
// Datapath: list memories, counts, limit register, ripple insert and result registers.
module pssu_dp import pssu_pkg::*; #(
    parameter int unsigned LIST_DEPTH = DEFAULT_LIST_DEPTH,
    parameter int unsigned VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CNT_W-1:0]      cfg_limit,
    input  logic [VALUE_BITS-1:0] item_value,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    output logic [STATUS_W-1:0]   res_status,
    output logic                  res_list,
    output logic [CNT_W-1:0]      res_count,
    output logic                  res_both_full
);

    localparam int unsigned IDX_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int unsigned DEPTH_CAP = (LIST_DEPTH > 31) ? 31 : LIST_DEPTH;
    localparam cnt_t        DEPTH_LIM = CNT_W'(DEPTH_CAP);

    cnt_t                  limit_reg;
    cnt_t                  even_cnt_reg, even_cnt_next;
    cnt_t                  odd_cnt_reg, odd_cnt_next;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  sel_reg;
    logic [VALUE_BITS-1:0] carry_reg, carry_next;
    logic                  ripple_reg, ripple_next;
    cnt_t                  idx_reg, idx_next;

    status_t               res_status_reg;
    logic                  res_list_reg;
    cnt_t                  res_count_reg;
    logic                  res_both_reg;

    cnt_t                  eff_lim;
    cnt_t                  cnt_sel;
    cnt_t                  idx_inc;
    logic [VALUE_BITS-1:0] even_rd, odd_rd, rd_data;
    logic                  shift_wr;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_idx;
    logic                  both_full;

    assign eff_lim   = (limit_reg > DEPTH_LIM) ? DEPTH_LIM : limit_reg;
    assign cnt_sel   = sel_reg ? odd_cnt_reg : even_cnt_reg;
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign rd_data   = sel_reg ? odd_rd : even_rd;
    assign both_full = (even_cnt_reg >= eff_lim) && (odd_cnt_reg >= eff_lim);

    assign stat.full  = cnt_sel >= eff_lim;
    assign stat.empty = cnt_sel == '0;
    assign stat.dup   = !ripple_reg && (rd_data == value_reg);
    assign stat.last  = idx_inc == cnt_sel;

    // Once the insert point is passed, every entry below moves down one slot
    assign shift_wr = ripple_reg || (rd_data < value_reg);

    always_comb
    begin
        wr_en         = 1'b0;
        wr_idx        = IDX_W'(idx_reg);
        rd_en         = 1'b0;
        rd_idx        = IDX_W'(idx_inc);
        carry_next    = carry_reg;
        ripple_next   = ripple_reg;
        idx_next      = idx_reg;
        even_cnt_next = even_cnt_reg;
        odd_cnt_next  = odd_cnt_reg;

        if (cmd.load_item)
        begin
            carry_next  = item_value;
            ripple_next = 1'b0;
        end

        if (cmd.read_first)
        begin
            rd_en    = 1'b1;
            rd_idx   = '0;
            idx_next = '0;
        end

        if (cmd.walk)
        begin
            rd_en    = 1'b1;
            idx_next = idx_inc;
            if (shift_wr && !stat.dup)
            begin
                wr_en       = 1'b1;
                carry_next  = rd_data;
                ripple_next = 1'b1;
            end
        end

        if (cmd.tail)
        begin
            wr_en  = 1'b1;
            wr_idx = IDX_W'(cnt_sel);
            if (sel_reg)
            begin
                odd_cnt_next = odd_cnt_reg + CNT_W'(1);
            end
            else
            begin
                even_cnt_next = even_cnt_reg + CNT_W'(1);
            end
        end
    end

    pssu_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (LIST_DEPTH)
    ) u_even_ram (
        .clk   (clk),
        .we    (wr_en && !sel_reg),
        .waddr (wr_idx),
        .wdata (carry_reg),
        .re    (rd_en && !sel_reg),
        .raddr (rd_idx),
        .rdata (even_rd)
    );

    pssu_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (LIST_DEPTH)
    ) u_odd_ram (
        .clk   (clk),
        .we    (wr_en && sel_reg),
        .waddr (wr_idx),
        .wdata (carry_reg),
        .re    (rd_en && sel_reg),
        .raddr (rd_idx),
        .rdata (odd_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= LIMIT_RESET;
            even_cnt_reg <= '0;
            odd_cnt_reg  <= '0;
            ripple_reg   <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_limit;
            end
            even_cnt_reg <= even_cnt_next;
            odd_cnt_reg  <= odd_cnt_next;
            ripple_reg   <= ripple_next;
            idx_reg      <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
        if (cmd.load_item)
        begin
            value_reg <= item_value;
            sel_reg   <= item_value[0];
        end
        if (cmd.load_result)
        begin
            res_status_reg <= cmd.status;
            res_list_reg   <= sel_reg;
            res_count_reg  <= cnt_sel;
            res_both_reg   <= both_full;
        end
    end

    assign res_status    = res_status_reg;
    assign res_list      = res_list_reg;
    assign res_count     = res_count_reg;
    assign res_both_full = res_both_reg;

endmodule

@@ sv/parity_split_sorted_unique_insert.sv @@
// Top level of the parity-split sorted unique insert block.
//
// Keeps two bounded lists, even and odd values, each in descending order
// without duplicates. Bit 0 of an item's value picks the list.
// Channels: item (sink) takes one value per transaction; result (source)
// returns one transaction per item with status, list used, that list's
// count and the both-full flag; cfg (sink) writes list_limit and is
// always ready. Write cfg only while no item is in flight.
// An accepted item goes to a start state that checks for a full list and
// reads the first entry, then walks the chosen list entry by entry, writes
// the tail slot and loads the result; a duplicate ends the walk early, and
// a full or empty list skips the walk (a full one also skips the tail).
// One item is in work at a time; the next item can be taken in the cycle
// after the previous item's result is loaded.
// The walk reads one entry per cycle from the list RAM's read port while
// the shifted entry is written back through its write port.
// Reset clears both counts and sets list_limit to 10; the list RAMs are
// not cleared since only slots below the count are ever used.
// A stalled receiver holds the result register; the block finishes the
// current item and waits for the register to drain before loading it.
module parity_split_sorted_unique_insert import pssu_pkg::*; #(
    parameter int unsigned LIST_DEPTH = DEFAULT_LIST_DEPTH,
    parameter int unsigned VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input logic                  clk,
    input logic                  rst_n,
    pssu_item_if.sink            item,
    pssu_result_if.source        result,
    pssu_cfg_if.sink             cfg
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg.ready = 1'b1;

    pssu_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    pssu_dp #(
        .LIST_DEPTH (LIST_DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg.valid && cfg.ready),
        .cfg_limit     (cfg.list_limit),
        .item_value    (item.value),
        .cmd           (cmd),
        .stat          (stat),
        .res_status    (result.status),
        .res_list      (result.list_used),
        .res_count     (result.list_count),
        .res_both_full (result.both_full)
    );

    // Only one item in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> !item.ready)
        else $error("item accepted while previous item still in work");

    // Never overwrite a result the receiver has not taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> (!result.valid || result.ready))
        else $error("result register overwritten while stalled");

    // A duplicate ends the walk with no tail write
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk && stat.dup |=> !cmd.tail && !cmd.walk)
        else $error("list modified after duplicate found");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_item, cmd.read_first, cmd.walk, cmd.tail, cmd.load_result}))
        else $error("conflicting datapath commands");

endmodule

@@ bench/sorted_insert_checker.sv @@
// Checker for the parity-split sorted insert block: predicts each result and compares.
module sorted_insert_checker import pssu_pkg::*; #(
    parameter int unsigned LIST_DEPTH = DEFAULT_LIST_DEPTH,
    parameter int unsigned VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input logic    clk,
    input logic    rst_n,
    pssu_item_if   item,
    pssu_result_if result,
    pssu_cfg_if    cfg,
    output int     errors,
    output int     pending
);

    typedef struct packed {
        status_t status;
        logic    list_used;
        cnt_t    list_count;
        logic    both_full;
    } outcome_t;

    logic [VALUE_BITS-1:0] even_list [LIST_DEPTH];
    logic [VALUE_BITS-1:0] odd_list [LIST_DEPTH];
    int unsigned           even_count;
    int unsigned           odd_count;
    int unsigned           limit_reg;
    outcome_t              outcome_q [$];

    function automatic outcome_t apply_insert(input logic [VALUE_BITS-1:0] v);
        int                    cap;
        int                    n;
        int                    pos;
        int                    i;
        logic [VALUE_BITS-1:0] row [LIST_DEPTH];
        outcome_t              res;
        cap = (limit_reg > LIST_DEPTH) ? LIST_DEPTH : limit_reg;
        if (v[0])
        begin
            row = odd_list;
            n = odd_count;
        end
        else
        begin
            row = even_list;
            n = even_count;
        end
        pos = 0;
        // A full list wins over a duplicate
        if (n >= cap)
        begin
            res.status = STATUS_FULL;
        end
        else
        begin
            while (pos < n && row[pos] > v)
                pos++;
            if (pos < n && row[pos] == v)
            begin
                res.status = STATUS_DUPLICATE;
            end
            else
            begin
                // Shift the smaller entries down one slot
                for (i = n; i > pos; i--)
                    row[i] = row[i-1];
                row[pos] = v;
                n++;
                res.status = STATUS_INSERTED;
            end
        end
        if (v[0])
        begin
            odd_list = row;
            odd_count = n;
        end
        else
        begin
            even_list = row;
            even_count = n;
        end
        res.list_used = v[0];
        res.list_count = cnt_t'(n);
        res.both_full = (even_count >= cap) && (odd_count >= cap);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            even_count = 0;
            odd_count = 0;
            limit_reg = LIMIT_RESET;
            outcome_q.delete();
            errors = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                limit_reg = cfg.list_limit;
            if (result.valid && result.ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, %s %0d %0d %0d %0d",
                             $time, "actual status/list/count/both_full",
                             result.status, result.list_used, result.list_count,
                             result.both_full);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    check_field("status", 8'(want.status), 8'(result.status));
                    check_field("list_used", 8'(want.list_used), 8'(result.list_used));
                    check_field("list_count", 8'(want.list_count), 8'(result.list_count));
                    check_field("both_full", 8'(want.both_full), 8'(result.both_full));
                end
            end
            if (item.valid && item.ready)
                outcome_q.push_back(apply_insert(item.value));
        end
        pending = outcome_q.size();
    end

endmodule

@@ bench/tb_parity_split_sorted_unique_insert.sv @@
// Testbench top: drives items, result stalls and limit writes, and gives the verdict.
module tb_parity_split_sorted_unique_insert;
    import pssu_pkg::*;

    localparam int RANDOM_PER_PHASE = 180;
    localparam logic [7:0] DIRECTED_VALUES [13] =
        '{8'd0, 8'd0, 8'd2, 8'd254, 8'd100, 8'd254, 8'd2,
          8'd1, 8'd255, 8'd129, 8'd127, 8'd3, 8'd129};
    localparam cnt_t PHASE_LIMITS [6] = '{5'd7, 5'd1, 5'd12, 5'd20, 5'd16, 5'd31};

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    int         errors;
    int         pending;
    bit         item_burst = 1'b0;
    bit         result_burst = 1'b0;
    logic [7:0] sent_values [$];

    pssu_item_if   item_ch ();
    pssu_result_if result_ch ();
    pssu_cfg_if    cfg_ch ();

    parity_split_sorted_unique_insert dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    sorted_insert_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .cfg     (cfg_ch),
        .errors  (errors),
        .pending (pending)
    );

    always #2 clk = ~clk;

    function automatic int draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, 15);
    endfunction

    task automatic send_value(input logic [7:0] v);
        int gap;
        @(negedge clk);
        if ($urandom_range(0, 39) == 0)
            item_burst = !item_burst;
        gap = draw_wait(item_burst);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.value <= v;
        sent_values.push_back(v);
        do @(posedge clk); while (!item_ch.ready);
    endtask

    // Drain all outstanding results before touching the limit
    task automatic write_limit(input cnt_t lim);
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.list_limit <= lim;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        item_ch.valid = 1'b0;
        item_ch.value = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.list_limit = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Reset limit: inserts into empty lists, head and middle inserts, zero value, duplicates
        foreach (DIRECTED_VALUES[i])
            send_value(DIRECTED_VALUES[i]);

        // Limit zero: every list counts as full
        write_limit(5'd0);
        send_value(8'd0);
        send_value(8'd255);
        send_value(8'd77);
        send_value(8'd200);

        // Full before duplicate, then a fresh value into a full list
        write_limit(5'd3);
        send_value(8'd254);
        send_value(8'd9);

        foreach (PHASE_LIMITS[p])
        begin
            write_limit(PHASE_LIMITS[p]);
            repeat (RANDOM_PER_PHASE)
            begin
                if ($urandom_range(0, 1) == 1)
                    send_value(sent_values[$urandom_range(0, sent_values.size() - 1)]);
                else
                    send_value(8'($urandom_range(0, 255)));
            end
        end

        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (errors == 0)
            $display("parity_split_sorted_unique_insert verification clean");
        else
            $display("parity_split_sorted_unique_insert verification failed");
        $finish;
    end

    initial
    begin
        int stall;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 39) == 0)
                result_burst = !result_burst;
            stall = draw_wait(result_burst);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
        end
    end

    initial
    begin
        #2000000;
        $display("parity_split_sorted_unique_insert verification failed");
        $finish;
    end

endmodule
